// File: rtl/assert_macros.svh
// Assertion macros shared by the packet reorder window RTL.
// Simulation builds get concurrent assertions; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define PRW_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("prw assertion failed");

// antecedent implies consequent in the next cycle
`define PRW_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("prw assertion failed");

`else

`define PRW_ASSERT_IMPL(name, clk, rst, ante, cons)
`define PRW_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// File: rtl/prw_pkg.sv
// Shared types and constants of the packet reorder window.
// No dependencies.
`timescale 1ns / 1ps

package prw_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SEQ_BITS_W = 5;
  localparam int WIN_W      = 5;
  localparam int INIT_W     = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_SEQ = 2'd2;

  localparam logic [SEQ_BITS_W-1:0] RST_SEQ_BITS = 5'd16;
  localparam logic [WIN_W-1:0]      RST_WIN_SIZE = 5'd16;
  localparam logic [INIT_W-1:0]     RST_INIT_SEQ = 16'd0;

  typedef enum logic [2:0] {
    KIND_RELEASED = 3'd0,
    KIND_BUFFERED = 3'd1,
    KIND_DROPPED  = 3'd2,
    KIND_WAITING  = 3'd3,
    KIND_REPORT   = 3'd4
  } kind_t;

  // control from the configuration registers to the engine
  typedef struct packed {
    logic hold;     // config write in progress, no new transaction
    logic restart;  // reload expected number, empty the window
  } cfg_ctl_t;

endpackage

// File: rtl/prw_slot_ram.sv
// Slot memory of the reorder window: one sequence number per window slot.
// Synchronous write, registered read. No dependencies.
`timescale 1ns / 1ps

module prw_slot_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/prw_engine.sv
// Reorder engine: expected number, slot occupancy, sequencer and output register.
// Uses prw_pkg, assert_macros.svh; drives the slot memory prw_slot_ram.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module prw_engine #(
  parameter int SEQ_WIDTH  = 16,
  parameter int WINDOW_MAX = 16,
  parameter int IDX_W      = 4,
  parameter int CNT_W      = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  prw_pkg::cfg_ctl_t     ctl,
  input  logic [SEQ_WIDTH-1:0]  seq_mask,
  input  logic [CNT_W-1:0]      win_eff,
  input  logic [SEQ_WIDTH-1:0]  init_eff,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  req_type,
  input  logic [SEQ_WIDTH-1:0]  packet_seq,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_kind,
  output logic [SEQ_WIDTH-1:0]  out_seq,
  output logic [SEQ_WIDTH-1:0]  out_exp,
  output logic                  out_last,
  output logic                  ram_we,
  output logic [IDX_W-1:0]      ram_waddr,
  output logic [SEQ_WIDTH-1:0]  ram_wdata,
  output logic                  ram_re,
  output logic [IDX_W-1:0]      ram_raddr,
  input  logic [SEQ_WIDTH-1:0]  ram_rdata
);

  localparam int CW = (SEQ_WIDTH > CNT_W) ? SEQ_WIDTH : CNT_W;
  localparam logic [IDX_W:0]   WIN_LIM = (IDX_W+1)'(WINDOW_MAX);
  localparam logic [IDX_W-1:0] LAST_D  = IDX_W'(WINDOW_MAX - 1);
  localparam logic [IDX_W-1:0] FIRST_D = IDX_W'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_CHAIN,
    S_FLUSH,
    S_FLUSH_OUT,
    S_REPORT
  } state_t;

  state_t                state;
  logic                  item_flush;
  logic [SEQ_WIDTH-1:0]  item_seq;
  logic [SEQ_WIDTH-1:0]  expected;
  logic [IDX_W-1:0]      head;
  logic [IDX_W-1:0]      dcnt;
  logic [WINDOW_MAX-1:0] occ;
  prw_pkg::kind_t        kind_q;

  logic [SEQ_WIDTH-1:0]  seq_dist;
  logic                  dist_zero;
  logic                  out_of_range;
  logic                  in_win;
  logic [IDX_W-1:0]      slot_off;
  logic [IDX_W:0]        slot_sum;
  logic [IDX_W-1:0]      slot;
  logic [IDX_W-1:0]      head_inc;
  logic [SEQ_WIDTH-1:0]  exp_inc;
  logic                  out_free;

  assign out_free     = !out_valid || out_ready;
  assign in_ready     = (state == S_IDLE) && !ctl.hold;
  assign out_kind     = kind_q;

  assign seq_dist     = (item_seq - expected) & seq_mask;
  assign dist_zero    = (seq_dist == '0);
  assign out_of_range = |(item_seq & ~seq_mask);
  assign in_win       = CW'(seq_dist) < CW'(win_eff);
  assign exp_inc      = (expected + 1'b1) & seq_mask;
  assign head_inc     = (head == LAST_D) ? '0 : head + 1'b1;

  // slot of a distance ahead of the expected number, circular over the memory
  assign slot_off = (state == S_FLUSH || state == S_FLUSH_OUT) ? dcnt
                                                               : IDX_W'(seq_dist);
  assign slot_sum = {1'b0, head} + {1'b0, slot_off};
  assign slot     = (slot_sum >= WIN_LIM) ? IDX_W'(slot_sum - WIN_LIM)
                                          : IDX_W'(slot_sum);

  assign ram_waddr = slot;
  assign ram_wdata = item_seq;

  // writes happen only on a decision, reads on an in-order decision, in the
  // release chain or the flush scan, so no access to one entry can overlap another
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = head_inc;
    unique case (state)
      S_DECIDE: begin
        if (out_free && !item_flush && !out_of_range) begin
          if (dist_zero) begin
            ram_re = occ[head_inc];
          end else if (in_win && !occ[slot]) begin
            ram_we = 1'b1;
          end
        end
      end
      S_CHAIN: begin
        ram_re = out_free && occ[head_inc];
      end
      S_FLUSH: begin
        ram_re    = occ[slot];
        ram_raddr = slot;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      occ       <= '0;
      expected  <= '0;
      head      <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            item_flush <= req_type;
            item_seq   <= packet_seq;
            state      <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (out_free) begin
            if (item_flush) begin
              dcnt  <= FIRST_D;
              state <= S_FLUSH;
            end else begin
              out_valid <= 1'b1;
              out_seq   <= item_seq;
              out_exp   <= expected;
              out_last  <= 1'b1;
              state     <= S_IDLE;
              priority if (out_of_range) begin
                kind_q <= prw_pkg::KIND_DROPPED;
              end else if (dist_zero) begin
                kind_q   <= prw_pkg::KIND_RELEASED;
                out_exp  <= exp_inc;
                out_last <= !occ[head_inc];
                expected <= exp_inc;
                head     <= head_inc;
                if (occ[head_inc]) begin
                  state <= S_CHAIN;
                end
              end else if (!in_win || occ[slot]) begin
                kind_q <= prw_pkg::KIND_DROPPED;
              end else begin
                kind_q    <= prw_pkg::KIND_BUFFERED;
                occ[slot] <= 1'b1;
              end
            end
          end
        end
        S_CHAIN: begin
          // memory data of the slot at head is ready in this state
          if (out_free) begin
            out_valid <= 1'b1;
            kind_q    <= prw_pkg::KIND_RELEASED;
            out_seq   <= ram_rdata;
            out_exp   <= exp_inc;
            out_last  <= !occ[head_inc];
            occ[head] <= 1'b0;
            expected  <= exp_inc;
            head      <= head_inc;
            if (!occ[head_inc]) begin
              state <= S_IDLE;
            end
          end
        end
        S_FLUSH: begin
          if (occ[slot]) begin
            state <= S_FLUSH_OUT;
          end else if (dcnt == LAST_D) begin
            state <= S_REPORT;
          end else begin
            dcnt <= dcnt + 1'b1;
          end
        end
        S_FLUSH_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            kind_q    <= prw_pkg::KIND_WAITING;
            out_seq   <= ram_rdata;
            out_exp   <= expected;
            out_last  <= 1'b0;
            occ[slot] <= 1'b0;
            if (dcnt == LAST_D) begin
              state <= S_REPORT;
            end else begin
              dcnt  <= dcnt + 1'b1;
              state <= S_FLUSH;
            end
          end
        end
        S_REPORT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            kind_q    <= prw_pkg::KIND_REPORT;
            out_seq   <= expected;
            out_exp   <= expected;
            out_last  <= 1'b1;
            occ       <= '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // a config write to a defined register restarts the window
      if (ctl.restart) begin
        state     <= S_IDLE;
        out_valid <= 1'b0;
        occ       <= '0;
        expected  <= init_eff;
        head      <= '0;
      end
    end
  end

  `PRW_ASSERT_IMPL(a_chain_slot_full, clk, rst, state == S_CHAIN, occ[head])
  `PRW_ASSERT_IMPL(a_idle_head_empty, clk, rst, state == S_IDLE, !occ[head])
  `PRW_ASSERT_IMPL(a_more_follow, clk, rst, out_valid && !out_last, state != S_IDLE)
  `PRW_ASSERT_NEXT(a_report_empties, clk, rst, state == S_REPORT && out_free, occ == '0)
  `PRW_ASSERT_IMPL(a_release_exp, clk, rst,
                   out_valid && !ctl.restart && kind_q == prw_pkg::KIND_RELEASED,
                   out_exp == ((out_seq + 1'b1) & seq_mask))

endmodule

// File: rtl/packet_reorder_window.sv
// Top level of the packet reorder window: configuration registers and wiring
// of the engine to its slot memory. Uses prw_pkg, prw_engine, prw_slot_ram.
`timescale 1ns / 1ps

//  channel   signals                                     handshake
//  in        req_type, packet_seq                        in_valid / in_ready
//  out       kind, seq_value, expected_seq, last         out_valid / out_ready
//  cfg       cfg_index, cfg_data                         cfg_we, no wait
//
//  An arrival is accepted, then decided in the slot memory; each further packet
//  released by it is paced by the memory read.
//  A flush is accepted and decided, then scans WINDOW_MAX - 1 slots, one per cycle
//  while empty even under a stall, with an output per waiting packet, then reports.
//  Reset is synchronous; a defined config write restarts the window via a registered
//  pulse, with in_ready low meanwhile. A stalled output register otherwise holds the engine.

module packet_reorder_window #(
  parameter int SEQ_WIDTH  = 16,
  parameter int WINDOW_MAX = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             req_type,
  input  logic [SEQ_WIDTH-1:0]             packet_seq,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2:0]                       kind,
  output logic [SEQ_WIDTH-1:0]             seq_value,
  output logic [SEQ_WIDTH-1:0]             expected_seq,
  output logic                             last,
  input  logic                             cfg_we,
  input  logic [prw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [prw_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int IDX_W = $clog2(WINDOW_MAX);
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int WW    = (CNT_W > prw_pkg::WIN_W) ? CNT_W : prw_pkg::WIN_W;

  logic [prw_pkg::SEQ_BITS_W-1:0] seq_bits;
  logic [prw_pkg::WIN_W-1:0]      win_size;
  logic [prw_pkg::INIT_W-1:0]     init_seq;
  logic                           restart;

  logic [5:0]           bits_eff;
  logic [SEQ_WIDTH-1:0] seq_mask;
  logic [CNT_W-1:0]     win_eff;
  logic [SEQ_WIDTH-1:0] init_eff;
  prw_pkg::cfg_ctl_t    ctl;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [SEQ_WIDTH-1:0] ram_wdata;
  logic                 ram_re;
  logic [IDX_W-1:0]     ram_raddr;
  logic [SEQ_WIDTH-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_bits <= prw_pkg::RST_SEQ_BITS;
      win_size <= prw_pkg::RST_WIN_SIZE;
      init_seq <= prw_pkg::RST_INIT_SEQ;
      restart  <= 1'b0;
    end else begin
      restart <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          prw_pkg::CFG_SEQ_BITS: begin
            seq_bits <= cfg_data[prw_pkg::SEQ_BITS_W-1:0];
            restart  <= 1'b1;
          end
          prw_pkg::CFG_WIN_SIZE: begin
            win_size <= cfg_data[prw_pkg::WIN_W-1:0];
            restart  <= 1'b1;
          end
          prw_pkg::CFG_INIT_SEQ: begin
            init_seq <= cfg_data[prw_pkg::INIT_W-1:0];
            restart  <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // sequence width saturates to 1 .. SEQ_WIDTH
  always_comb begin
    if (seq_bits == '0) begin
      bits_eff = 6'd1;
    end else if (6'(seq_bits) > 6'(SEQ_WIDTH)) begin
      bits_eff = 6'(SEQ_WIDTH);
    end else begin
      bits_eff = 6'(seq_bits);
    end
    for (int i = 0; i < SEQ_WIDTH; i++) begin
      seq_mask[i] = 6'(i) < bits_eff;
    end
  end

  assign win_eff  = (WW'(win_size) > WW'(WINDOW_MAX)) ? CNT_W'(WINDOW_MAX) : CNT_W'(win_size);
  assign init_eff = SEQ_WIDTH'(init_seq) & seq_mask;

  assign ctl.hold    = cfg_we || restart;
  assign ctl.restart = restart;

  prw_engine #(
    .SEQ_WIDTH  (SEQ_WIDTH),
    .WINDOW_MAX (WINDOW_MAX),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .seq_mask   (seq_mask),
    .win_eff    (win_eff),
    .init_eff   (init_eff),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .packet_seq (packet_seq),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_kind   (kind),
    .out_seq    (seq_value),
    .out_exp    (expected_seq),
    .out_last   (last),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  prw_slot_ram #(
    .DATA_W (SEQ_WIDTH),
    .DEPTH  (WINDOW_MAX),
    .ADDR_W (IDX_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// File: tb/testbench.sv
// Self-checking testbench for packet_reorder_window: in-order release, window
// buffering, drops and flush reports against a cycle-free prediction.
// Depends on prw_pkg and the packet_reorder_window RTL.
`timescale 1ns / 1ps

module testbench;

  localparam logic                          REQ_PACKET     = 1'b0;
  localparam logic                          REQ_FLUSH      = 1'b1;
  localparam logic [prw_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int                            HELD_MAX       = 16;

  typedef struct {
    logic        flush;
    logic [15:0] seq;
    int unsigned gap;
  } req_item_t;

  typedef struct {
    prw_pkg::kind_t k;
    logic [15:0]    seq;
    logic [15:0]    nxt;
    logic           last;
  } outcome_t;

  typedef enum {
    NOISE_NONE, NOISE_LOSE_HEAD, NOISE_STRAY, NOISE_DUP, NOISE_FLUSH, NOISE_BORDER
  } noise_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           req_type = REQ_PACKET;
  logic [15:0]                    packet_seq = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [2:0]                     kind;
  logic [15:0]                    seq_value;
  logic [15:0]                    expected_seq;
  logic                           last;
  logic                           cfg_we = 1'b0;
  logic [prw_pkg::CFG_IDX_W-1:0]  cfg_index = prw_pkg::CFG_SEQ_BITS;
  logic [prw_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  packet_reorder_window u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .packet_seq  (packet_seq),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .seq_value   (seq_value),
    .expected_seq(expected_seq),
    .last        (last),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  // stimulus and scoreboard state
  req_item_t   arrival_q[$];
  outcome_t    outcome_q[$];
  int          sent_cnt   = 0;
  int          taken_cnt  = 0;
  int          mismatches = 0;
  int          tx_wait    = 0;
  int          rx_wait    = 0;
  bit          calm       = 1'b0;
  req_item_t   next_req;
  outcome_t    want;

  // predicted window state
  logic [4:0]  reg_seq_bits = prw_pkg::RST_SEQ_BITS;
  logic [4:0]  reg_win_size = prw_pkg::RST_WIN_SIZE;
  logic [15:0] reg_init_seq = prw_pkg::RST_INIT_SEQ;
  logic [15:0] next_seq = prw_pkg::RST_INIT_SEQ;
  logic [15:0] held [HELD_MAX];
  int          held_cnt = 0;

  function automatic logic [15:0] seq_mask();
    int b;
    b = reg_seq_bits;
    if (b < 1) b = 1;
    if (b > 16) b = 16;
    return 16'((32'd1 << b) - 1);
  endfunction

  function automatic int window_eff();
    return (reg_win_size > HELD_MAX) ? HELD_MAX : int'(reg_win_size);
  endfunction

  task automatic note_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic push_outcome(input prw_pkg::kind_t k, input logic [15:0] s,
                              input logic l);
    outcome_t ev;
    ev.k = k;
    ev.seq = s;
    ev.nxt = next_seq;
    ev.last = l;
    outcome_q.push_back(ev);
  endtask

  // predicts the results of one accepted transaction and updates the window
  task automatic predict_window(input logic flush, input logic [15:0] pkt);
    logic [15:0] m;
    logic [15:0] ahead;
    logic [15:0] s;
    bit          dup;
    int          pos;
    outcome_t    ev;
    m = seq_mask();
    if (flush == REQ_FLUSH) begin
      for (int i = 0; i < held_cnt; i++) push_outcome(prw_pkg::KIND_WAITING, held[i], 1'b0);
      held_cnt = 0;
      push_outcome(prw_pkg::KIND_REPORT, next_seq, 1'b1);
    end else if (pkt > m) begin
      push_outcome(prw_pkg::KIND_DROPPED, pkt, 1'b1);
    end else begin
      ahead = (pkt - next_seq) & m;
      dup = 1'b0;
      for (int i = 0; i < held_cnt; i++) if (held[i] == pkt) dup = 1'b1;
      if (ahead == 0) begin
        next_seq = (next_seq + 16'd1) & m;
        push_outcome(prw_pkg::KIND_RELEASED, pkt, 1'b0);
        while (held_cnt > 0 && held[0] == next_seq) begin
          s = held[0];
          for (int i = 0; i < held_cnt - 1; i++) held[i] = held[i+1];
          held_cnt--;
          next_seq = (next_seq + 16'd1) & m;
          push_outcome(prw_pkg::KIND_RELEASED, s, 1'b0);
        end
        ev = outcome_q.pop_back();
        ev.last = 1'b1;
        outcome_q.push_back(ev);
      end else if (ahead >= window_eff() || held_cnt >= HELD_MAX || dup) begin
        push_outcome(prw_pkg::KIND_DROPPED, pkt, 1'b1);
      end else begin
        pos = 0;
        while (pos < held_cnt && ((held[pos] - next_seq) & m) < ahead) pos++;
        for (int i = held_cnt; i > pos; i--) held[i] = held[i-1];
        held[pos] = pkt;
        held_cnt++;
        push_outcome(prw_pkg::KIND_BUFFERED, pkt, 1'b1);
      end
    end
  endtask

  // driver: one transaction at a time from arrival_q, with a per-item idle gap
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_window(req_type, packet_seq);
        taken_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (arrival_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (tx_wait < arrival_q[0].gap) begin
          tx_wait++;
          in_valid <= 1'b0;
        end else begin
          next_req = arrival_q.pop_front();
          tx_wait = 0;
          in_valid <= 1'b1;
          req_type <= next_req.flush;
          packet_seq <= next_req.seq;
        end
      end
    end
  end

  // monitor: compares each result with the oldest prediction, random stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (outcome_q.size() == 0) begin
          note_mismatch($sformatf("unexpected result kind=%0d seq=%h next=%h last=%b",
                                  kind, seq_value, expected_seq, last));
        end else begin
          want = outcome_q.pop_front();
          if (kind !== want.k || seq_value !== want.seq || expected_seq !== want.nxt ||
              last !== want.last)
            note_mismatch($sformatf("kind %0d/%0d seq %h/%h next %h/%h last %b/%b (got/exp)",
                                    kind, want.k, seq_value, want.seq, expected_seq,
                                    want.nxt, last, want.last));
        end
        rx_wait = calm ? 0 : $urandom_range(0, 11);
      end
      if (rx_wait != 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic queue_req(input logic flush, input logic [15:0] seq);
    req_item_t it;
    it.flush = flush;
    it.seq = (flush == REQ_FLUSH) ? 16'($urandom) : seq;
    it.gap = calm ? 0 : $urandom_range(0, 11);
    arrival_q.push_back(it);
    sent_cnt++;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (taken_cnt != sent_cnt || outcome_q.size() != 0);
  endtask

  // one register write; any real register restarts the window
  task automatic write_reg(input logic [prw_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx != CFG_UNUSED_IDX) begin
      if (idx == prw_pkg::CFG_SEQ_BITS) reg_seq_bits = val[4:0];
      else if (idx == prw_pkg::CFG_WIN_SIZE) reg_win_size = val[4:0];
      else reg_init_seq = val;
      held_cnt = 0;
      next_seq = reg_init_seq & seq_mask();
    end
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    req_item_t   burst[$];
    req_item_t   it;
    req_item_t   tmp;
    noise_t      noise;
    logic [15:0] m;
    logic [4:0]  sb;
    logic [4:0]  ws;
    int          w;
    int          span;
    int          kmax;
    int          k;
    int          j;
    int          idx;
    int          sel;
    int          rnd_count;
    int          phase_at;
    bit          wrote;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: full 16-bit numbers, window of 16
    queue_req(REQ_PACKET, 16'd0);
    queue_req(REQ_PACKET, 16'd3);
    queue_req(REQ_PACKET, 16'd16);     // farthest accepted distance
    queue_req(REQ_PACKET, 16'd17);     // just past the window
    queue_req(REQ_PACKET, 16'd3);      // already waiting
    queue_req(REQ_PACKET, 16'd2);      // ordered insert ahead of 3
    queue_req(REQ_PACKET, 16'hFFFF);   // behind
    queue_req(REQ_FLUSH, 16'd0);
    queue_req(REQ_FLUSH, 16'd0);       // empty store
    queue_req(REQ_PACKET, 16'd2);
    queue_req(REQ_PACKET, 16'd1);      // releases a chain
    wait_idle();

    // modulus 8, window 4, init beyond the modulus; release wraps through zero
    write_reg(prw_pkg::CFG_SEQ_BITS, 16'd3);
    write_reg(prw_pkg::CFG_WIN_SIZE, 16'd4);
    write_reg(prw_pkg::CFG_INIT_SEQ, 16'hFFFE);
    end_writes();
    queue_req(REQ_PACKET, 16'd8);
    queue_req(REQ_PACKET, 16'd1);
    queue_req(REQ_PACKET, 16'd2);
    queue_req(REQ_PACKET, 16'd7);
    queue_req(REQ_PACKET, 16'd0);
    queue_req(REQ_PACKET, 16'd6);
    queue_req(REQ_PACKET, 16'd4);      // left waiting across the restart
    wait_idle();

    // zero sequence bits saturate to one, window zero buffers nothing
    write_reg(prw_pkg::CFG_SEQ_BITS, 16'd0);
    write_reg(prw_pkg::CFG_WIN_SIZE, 16'd0);
    write_reg(prw_pkg::CFG_INIT_SEQ, 16'hFFFF);
    end_writes();
    queue_req(REQ_PACKET, 16'd0);
    queue_req(REQ_PACKET, 16'd1);
    queue_req(REQ_PACKET, 16'h8000);
    wait_idle();

    // oversized settings saturate
    write_reg(prw_pkg::CFG_SEQ_BITS, 16'd31);
    write_reg(prw_pkg::CFG_WIN_SIZE, 16'd31);
    write_reg(prw_pkg::CFG_INIT_SEQ, 16'hFFF0);
    end_writes();
    queue_req(REQ_PACKET, 16'hFFFF);
    queue_req(REQ_PACKET, 16'h0000);
    queue_req(REQ_PACKET, 16'hFFF0);
    queue_req(REQ_FLUSH, 16'd0);

    rnd_count = 0;
    phase_at = 0;
    while (rnd_count < 410) begin
      if (rnd_count >= phase_at) begin
        wait_idle();
        sel = $urandom_range(0, 9);
        if (sel == 0) sb = 5'd0;
        else if (sel == 1) sb = 5'($urandom_range(17, 31));
        else if (sel == 2) sb = 5'd16;
        else if (sel == 3) sb = 5'($urandom_range(7, 15));
        else sb = 5'($urandom_range(1, 6));
        sel = $urandom_range(0, 9);
        if (sel == 0) ws = 5'($urandom_range(0, 1));
        else if (sel == 1) ws = 5'($urandom_range(17, 31));
        else if (sel == 2) ws = 5'd16;
        else ws = 5'($urandom_range(2, 16));
        wrote = 1'b0;
        if ($urandom_range(0, 3) != 0) begin
          write_reg(prw_pkg::CFG_WIN_SIZE, {11'($urandom), ws});
          wrote = 1'b1;
        end
        if ($urandom_range(0, 3) != 0) begin
          write_reg(prw_pkg::CFG_INIT_SEQ, 16'($urandom));
          wrote = 1'b1;
        end
        if (!wrote || $urandom_range(0, 3) != 0)
          write_reg(prw_pkg::CFG_SEQ_BITS, {11'($urandom), sb});
        if ($urandom_range(0, 4) == 0) write_reg(CFG_UNUSED_IDX, 16'($urandom));
        end_writes();
        phase_at = phase_at + $urandom_range(35, 60);
      end else if ($urandom_range(0, 9) == 0) begin
        wait_idle();
      end
      calm = ($urandom_range(0, 3) == 0);
      // next burst is built around the window position once all is taken
      while (taken_cnt != sent_cnt) @(posedge clk);

      m = seq_mask();
      w = window_eff();
      span = (m < 16'd15) ? int'(m) + 1 : HELD_MAX;
      kmax = (w < span) ? w : span;
      if (kmax < 1) kmax = 1;
      k = $urandom_range(1, kmax);
      burst.delete();
      for (int i = 0; i < k; i++) begin
        it.flush = REQ_PACKET;
        it.seq = (next_seq + 16'(i)) & m;
        it.gap = 0;
        burst.push_back(it);
      end
      for (int i = k - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = burst[i];
        burst[i] = burst[j];
        burst[j] = tmp;
      end

      noise = NOISE_NONE;
      if ($urandom_range(0, 1) != 0) noise = noise_t'($urandom_range(1, 5));
      it.flush = REQ_PACKET;
      case (noise)
        NOISE_LOSE_HEAD: begin
          idx = -1;
          for (int i = 0; i < burst.size(); i++) if (burst[i].seq == next_seq) idx = i;
          if (idx >= 0) burst.delete(idx);
          if ($urandom_range(0, 1) != 0) begin
            it.flush = REQ_FLUSH;
            burst.push_back(it);
          end
        end
        NOISE_STRAY: begin
          it.seq = 16'($urandom);
          burst.insert($urandom_range(0, burst.size()), it);
        end
        NOISE_DUP: begin
          it = burst[$urandom_range(0, burst.size() - 1)];
          burst.insert($urandom_range(0, burst.size()), it);
        end
        NOISE_FLUSH: begin
          it.flush = REQ_FLUSH;
          burst.insert($urandom_range(0, burst.size()), it);
        end
        NOISE_BORDER: begin
          it.seq = (next_seq + 16'(w)) & m;
          burst.insert($urandom_range(0, burst.size()), it);
          it.seq = (next_seq - 16'd1) & m;
          burst.insert($urandom_range(0, burst.size()), it);
        end
        default: ;
      endcase

      foreach (burst[i]) queue_req(burst[i].flush, burst[i].seq);
      rnd_count = rnd_count + burst.size();
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #6000000;
    $display("FAIL");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/prw_pkg.sv
rtl/prw_slot_ram.sv
rtl/prw_engine.sv
rtl/packet_reorder_window.sv
tb/testbench.sv
